/* hdl/utf8rev_pkg.sv */
// Shared constants, types and helpers for the UTF-8 aware string reverser.
// No dependencies; imported by utf8rev_fill, utf8rev_drain and the top level.
package utf8rev_pkg;

   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'hE0;
   localparam logic [BYTE_W-1:0] CODE_LEAD2  = 8'hC0;
   localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'hF0;
   localparam logic [BYTE_W-1:0] CODE_LEAD3  = 8'hE0;
   localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'hF8;
   localparam logic [BYTE_W-1:0] CODE_LEAD4  = 8'hF0;

   // Handoff from the fill side to the drain side when a string is complete.
   typedef struct packed {
      logic go;
      logic overflow;
   } launch_type;

   // Continuation bytes that follow a lead byte; invalid leads count as single bytes.
   function automatic logic [1:0] lead_extra(input logic [BYTE_W-1:0] b);
      logic [1:0] n;
      n = 2'd0;
      if (b < ASCII_LIMIT) begin
         n = 2'd0;
      end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
         n = 2'd1;
      end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
         n = 2'd2;
      end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

/* hdl/utf8rev_ram.sv */
// Simple dual-port string buffer: one write port, one read port with registered data.
// No dependencies.
module utf8rev_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6,
   parameter int unsigned DW    = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/utf8rev_fill.sv */
// Write side: accepts input bytes, tracks codepoint boundaries and fills the buffer.
// Depends on utf8rev_pkg.
module utf8rev_fill #(
   parameter int unsigned MAX_LEN = 64,
   parameter int unsigned AW      = 6,
   parameter int unsigned CW      = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tlast,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [7:0]                 wr_byte,
   output logic [AW-1:0]              wr_start,
   output utf8rev_pkg::launch_type    launch,
   output logic [CW-1:0]              launch_count,
   input  logic                       drain_done
);
   import utf8rev_pkg::*;

   logic [CW-1:0] fill_ff, fill_in;
   logic [1:0]    pend_ff, pend_in;
   logic [AW-1:0] cur_start_ff, cur_start_in;
   logic          ovf_ff, ovf_in;
   logic          busy_ff, busy_in;
   logic          accept, room;
   logic [AW-1:0] start_idx;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign room       = fill_ff < CW'(MAX_LEN);
   assign start_idx  = (pend_ff == 2'd0) ? fill_ff[AW-1:0] : cur_start_ff;

   assign wr_en    = accept && room;
   assign wr_addr  = fill_ff[AW-1:0];
   assign wr_byte  = req_tdata;
   assign wr_start = start_idx;

   assign launch.go       = accept && req_tlast;
   assign launch.overflow = ovf_ff || !room;
   assign launch_count    = room ? fill_ff + 1'b1 : fill_ff;

   always_comb begin
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      cur_start_in = cur_start_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff;
      if (drain_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (room) begin
            fill_in      = fill_ff + 1'b1;
            cur_start_in = start_idx;
            pend_in      = (pend_ff == 2'd0) ? lead_extra(req_tdata) : pend_ff - 2'd1;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_tlast) begin
            // The string is handed to the drain side; counters restart for the next one.
            fill_in = '0;
            pend_in = 2'd0;
            ovf_in  = 1'b0;
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 2'd0;
         ovf_ff  <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         ovf_ff  <= ovf_in;
         busy_ff <= busy_in;
      end
      cur_start_ff <= cur_start_in;
   end

endmodule

/* hdl/utf8rev_drain.sv */
// Read side: walks the buffer in reversed unit order and feeds the output register.
// Depends on utf8rev_pkg.
module utf8rev_drain #(
   parameter int unsigned AW = 6,
   parameter int unsigned CW = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mode,
   input  utf8rev_pkg::launch_type    launch,
   input  logic [CW-1:0]              launch_count,
   output logic                       drain_done,
   output logic [AW-1:0]              rd_addr,
   input  logic [7:0]                 rd_byte,
   input  logic [AW-1:0]              rd_start,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);
   import utf8rev_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEEK  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_SHOW  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] end_ff, end_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] unit_ff, unit_in;
   logic          mode_ff, mode_in;
   logic          ovf_ff, ovf_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic          out_ovf_ff;
   logic          out_free, load;
   logic [CW-1:0] end_m1, count_m1, pos_next;

   assign out_free = !out_valid_ff || rsp_tready;
   assign load     = (state_ff == ST_SHOW) && out_free;
   assign end_m1   = end_ff - 1'b1;
   assign count_m1 = launch_count - 1'b1;
   assign pos_next = CW'(pos_ff) + 1'b1;

   assign drain_done = load && (cnt_ff == CW'(1));
   assign rd_addr    = (state_ff == ST_SEEK) ? end_m1[AW-1:0] : pos_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      end_in   = end_ff;
      pos_in   = pos_ff;
      unit_in  = unit_ff;
      mode_in  = mode_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch.go) begin
               cnt_in  = launch_count;
               end_in  = launch_count;
               mode_in = mode;
               ovf_in  = launch.overflow;
               pos_in  = count_m1[AW-1:0];
               state_in = mode ? ST_SEEK : ST_READ;
            end
         end
         ST_SEEK: begin
            state_in = ST_START;
         end
         ST_START: begin
            // The entry just before the unit's end names where its codepoint begins.
            unit_in  = rd_start;
            pos_in   = rd_start;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (out_free) begin
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end else if (pos_next != end_ff) begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_READ;
               end else if (mode_ff) begin
                  end_in   = CW'(unit_ff);
                  state_in = ST_SEEK;
               end else begin
                  end_in   = CW'(pos_ff);
                  pos_in   = pos_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff  <= cnt_in;
      end_ff  <= end_in;
      pos_ff  <= pos_in;
      unit_ff <= unit_in;
      mode_ff <= mode_in;
      ovf_ff  <= ovf_in;
      if (load) begin
         out_byte_ff <= rd_byte;
         out_last_ff <= (cnt_ff == CW'(1));
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

/* hdl/utf8_aware_string_reverse_unit.sv */
// Top level of the UTF-8 aware string reverser: mode register and submodule wiring.
// Depends on utf8rev_pkg, utf8rev_ram, utf8rev_fill and utf8rev_drain.
//
// String bytes are stored one per cycle from req_, while req_tready is high, in a
// MAX_LEN-entry buffer; req_tlast closes the string and the block then plays the
// string back reversed on rsp_, with rsp_tlast on its final byte. With the mode
// register at 1 the order of UTF-8 codepoints is reversed and each codepoint keeps
// its byte order; at 0 the bytes are mirrored. Bytes past MAX_LEN are dropped and
// rsp_tuser is set on every byte of that string. The mode is sampled when the last
// byte arrives. Playback runs through the single registered read port of the
// buffer: each byte takes a read and a show step, and in codepoint mode each
// codepoint first takes a seek and a start step to look up where it begins; an
// output stall holds playback. req_tready is low from the last byte of a string
// until its final result is in the output register. No clearing pass is needed.
module utf8_aware_string_reverse_unit #(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   output logic       rsp_tuser,   // [0] overflowed
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // codepoint_mode
);
   import utf8rev_pkg::*;

   localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned CW = $clog2(MAX_LEN + 1);
   localparam int unsigned DW = BYTE_W + AW;

   logic          mode_ff, mode_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr, wr_start, rd_addr, rd_start;
   logic [7:0]    wr_byte, rd_byte;
   logic [DW-1:0] rd_data;
   launch_type    launch;
   logic [CW-1:0] launch_count;
   logic          drain_done;

   assign csr_ready = 1'b1;
   assign mode_in   = csr_valid ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   utf8rev_fill #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_fill (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_byte      (wr_byte),
      .wr_start     (wr_start),
      .launch       (launch),
      .launch_count (launch_count),
      .drain_done   (drain_done)
   );

   utf8rev_ram #(.DEPTH(MAX_LEN), .AW(AW), .DW(DW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_start, wr_byte}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_byte  = rd_data[BYTE_W-1:0];
   assign rd_start = rd_data[DW-1:BYTE_W];

   utf8rev_drain #(.AW(AW), .CW(CW)) u_drain (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .launch       (launch),
      .launch_count (launch_count),
      .drain_done   (drain_done),
      .rd_addr      (rd_addr),
      .rd_byte      (rd_byte),
      .rd_start     (rd_start),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

/* hdl/utf8rev_checker.sv */
// Port-level checks for the UTF-8 aware string reverser, bound to the top level.
// Depends only on the ports of utf8_aware_string_reverse_unit.
module utf8rev_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // Input is closed right after the last byte of a string is taken.
   a_close_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input accepted right after the last byte of a string");

   // Input reopens only once the final byte of the reversed string is presented.
   a_reopen_on_last: assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> rsp_tvalid && rsp_tlast)
      else $error("input reopened before the final result was ready");

   // Input is closed while a non-final result is presented.
   a_busy_while_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open during playback");

endmodule

bind utf8_aware_string_reverse_unit utf8rev_checker u_utf8rev_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
